// ===== rtl/mcc_pkg.sv =====
// shared types, constants and helpers of the pi motor control core
package mcc_pkg;

   // width of the shared arithmetic unit, wide enough for the pi sum and its differences
   localparam int AluW = 44;
   // multiplier operand widths: signed error side and unsigned gain side
   localparam int MulAW = 33;
   localparam int MulBW = 8;
   // remainder width of the serial divider: below tick_rate * 256
   localparam int RemW = 18;
   localparam logic [7:0] PwmMax = 8'd255;

   // operation codes of an input word
   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_ADD   = 3'd2,
      OP_STOP  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   // register indexes of the csr port
   typedef enum logic [1:0] {
      REG_DEFAULT_SPEED = 2'd0,
      REG_PROP_GAIN     = 2'd1,
      REG_INTEG_GAIN    = 2'd2,
      REG_TICK_RATE     = 2'd3
   } reg_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NEG,
      ST_VEL,
      ST_CMP,
      ST_ERR,
      ST_SUM,
      ST_MUL_P,
      ST_MUL_I,
      ST_ADD,
      ST_ABS,
      ST_CHK,
      ST_DIV,
      ST_FINISH
   } state_type;

   // operations of the shared arithmetic unit
   typedef enum logic [1:0] {
      AR_ADD,
      AR_SUB,
      AR_MUL
   } arith_op_type;

   // request to the shared arithmetic unit
   typedef struct packed {
      arith_op_type          op;
      logic signed [AluW-1:0] a;
      logic signed [AluW-1:0] b;
   } arith_req_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [AluW-1:0] v);
      logic signed [31:0] r;
      if ((&v[AluW-1:31]) || (~|v[AluW-1:31])) begin
         r = v[31:0];
      end else if (v[AluW-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// ===== rtl/mcc_arith.sv =====
// shared add, subtract and multiply unit of the pi motor control core
module mcc_arith (
   input  mcc_pkg::arith_req_type              req,
   output logic signed [mcc_pkg::AluW-1:0]     res
);

   logic signed [mcc_pkg::MulAW-1:0]             mul_a;
   logic signed [mcc_pkg::MulBW:0]               mul_b;
   logic signed [mcc_pkg::MulAW+mcc_pkg::MulBW:0] prod;

   // signed error or integral times unsigned gain
   assign mul_a = req.a[mcc_pkg::MulAW-1:0];
   assign mul_b = $signed({1'b0, req.b[mcc_pkg::MulBW-1:0]});
   assign prod  = mul_a * mul_b;

   // operation select
   always_comb begin
      case (req.op)
         mcc_pkg::AR_ADD: res = req.a + req.b;
         mcc_pkg::AR_SUB: res = req.a - req.b;
         mcc_pkg::AR_MUL: res = mcc_pkg::AluW'(prod);
         default:         res = req.a;
      endcase
   end

endmodule

// ===== rtl/pi_velocity_position_motor_control_core.sv =====
// top level of the pi velocity and position motor control core
//
//   channel | direction | handshake           | words
//   req_    | in        | req_valid/req_stall | operation, encoder count, distance
//   rsp_    | out       | rsp_valid/rsp_stall | pwm duty, reverse, done, speed, zero encoder
//   csr_    | in        | csr_valid/csr_ready | register index and write data
//
// a tick passes the negate, velocity, compare, error, sum, multiply, add, abs and check states
// and then the divider: every add, compare, multiply and divider step goes through one shared
// arithmetic unit, with the 8-bit quotient formed by 8 restoring steps. a tick whose drive
// saturates skips the divider, a tick that ends the move also skips the multiplies, and every
// other operation passes only the execute state. one word is in work at a time; req_stall is
// high from acceptance until the result is loaded into the output register, csr_ready only
// while idle. rsp_stall holds the result there and keeps the sequencer waiting before its
// last step. reset is synchronous.
module pi_velocity_position_motor_control_core (
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_encoder_count,
   input  logic signed [31:0] req_distance,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_pwm_duty,
   output logic               rsp_reverse,
   output logic               rsp_done_res,
   output logic signed [31:0] rsp_speed,
   output logic               rsp_zero_encoder,
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int AluW = mcc_pkg::AluW;
   localparam int RemW = mcc_pkg::RemW;

   mcc_pkg::state_type state_ff, state_in;

   // configuration registers
   logic signed [15:0] default_speed_ff;
   logic [7:0]         prop_gain_ff;
   logic [7:0]         integ_gain_ff;
   logic [9:0]         tick_rate_ff;

   // controller state
   logic signed [31:0] last_count_ff;
   logic signed [31:0] measured_speed_ff;
   logic signed [31:0] error_sum_ff;
   logic signed [16:0] speed_target_ff;
   logic signed [31:0] target_pos_ff;
   logic               move_done_ff;
   logic               drive_reverse_ff;

   // working registers of one word
   logic [2:0]         op_ff;
   logic signed [31:0] count_ff;
   logic signed [31:0] dist_ff;
   logic signed [32:0] pos_ff;
   logic signed [32:0] err_ff;
   logic               in_range_ff;
   logic signed [AluW-1:0] acc_ff;
   logic signed [AluW-1:0] prod_ff;
   logic               neg_ff;
   logic [RemW-1:0]    rem_ff;
   logic [7:0]         quo_ff;
   logic [2:0]         step_ff;
   logic [7:0]         pwm_ff;
   logic               zero_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_pwm_ff;
   logic               rsp_reverse_ff;
   logic               rsp_done_ff;
   logic signed [31:0] rsp_speed_ff;
   logic               rsp_zero_ff;

   mcc_pkg::arith_req_type   arith_req;
   logic signed [AluW-1:0]   arith_res;
   logic                     req_accept;
   logic                     rsp_load;
   logic                     csr_write;
   logic [9:0]               div_val;
   logic                     res_neg;
   logic                     res_pos;
   logic [7:0]               quo_next;

   mcc_arith u_arith (
      .req (arith_req),
      .res (arith_res)
   );

   // handshakes
   assign req_stall  = (state_ff != mcc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == mcc_pkg::ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_load   = (state_ff == mcc_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // a zero tick rate divides as one
   assign div_val  = (tick_rate_ff == 10'd0) ? 10'd1 : tick_rate_ff;
   assign res_neg  = arith_res[AluW-1];
   assign res_pos  = !arith_res[AluW-1] && (|arith_res);
   assign quo_next = quo_ff | (res_neg ? 8'd0 : (8'd1 << step_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_operation == mcc_pkg::OP_TICK) ? mcc_pkg::ST_NEG
                                                             : mcc_pkg::ST_EXEC;
            end
         end
         mcc_pkg::ST_EXEC:  state_in = mcc_pkg::ST_FINISH;
         mcc_pkg::ST_NEG:   state_in = mcc_pkg::ST_VEL;
         mcc_pkg::ST_VEL:   state_in = mcc_pkg::ST_CMP;
         mcc_pkg::ST_CMP:   state_in = mcc_pkg::ST_ERR;
         mcc_pkg::ST_ERR:   state_in = mcc_pkg::ST_SUM;
         mcc_pkg::ST_SUM:   state_in = in_range_ff ? mcc_pkg::ST_MUL_P : mcc_pkg::ST_FINISH;
         mcc_pkg::ST_MUL_P: state_in = mcc_pkg::ST_MUL_I;
         mcc_pkg::ST_MUL_I: state_in = mcc_pkg::ST_ADD;
         mcc_pkg::ST_ADD:   state_in = mcc_pkg::ST_ABS;
         mcc_pkg::ST_ABS:   state_in = mcc_pkg::ST_CHK;
         mcc_pkg::ST_CHK:   state_in = res_neg ? mcc_pkg::ST_DIV : mcc_pkg::ST_FINISH;
         mcc_pkg::ST_DIV:   state_in = (step_ff == 3'd0) ? mcc_pkg::ST_FINISH : mcc_pkg::ST_DIV;
         mcc_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = mcc_pkg::ST_IDLE;
            end
         end
         default: state_in = mcc_pkg::ST_IDLE;
      endcase
   end

   // operand selection for the shared arithmetic unit
   always_comb begin
      arith_req.op = mcc_pkg::AR_ADD;
      arith_req.a  = '0;
      arith_req.b  = '0;
      case (state_ff)
         mcc_pkg::ST_EXEC: begin
            if (op_ff == mcc_pkg::OP_START) begin
               arith_req.op = mcc_pkg::AR_SUB;
               arith_req.b  = AluW'(default_speed_ff);
            end else begin
               arith_req.a = AluW'(target_pos_ff);
               arith_req.b = AluW'(dist_ff);
            end
         end
         mcc_pkg::ST_NEG: begin
            if (speed_target_ff[16]) begin
               arith_req.op = mcc_pkg::AR_SUB;
               arith_req.b  = AluW'(count_ff);
            end else begin
               arith_req.a = AluW'(count_ff);
            end
         end
         mcc_pkg::ST_VEL: begin
            arith_req.op = mcc_pkg::AR_SUB;
            arith_req.a  = AluW'(pos_ff);
            arith_req.b  = AluW'(last_count_ff);
         end
         mcc_pkg::ST_CMP: begin
            arith_req.op = mcc_pkg::AR_SUB;
            arith_req.a  = AluW'(target_pos_ff);
            arith_req.b  = AluW'(pos_ff);
         end
         mcc_pkg::ST_ERR: begin
            arith_req.op = mcc_pkg::AR_SUB;
            arith_req.a  = AluW'(speed_target_ff);
            arith_req.b  = AluW'(measured_speed_ff);
         end
         mcc_pkg::ST_SUM: begin
            arith_req.a = AluW'(error_sum_ff);
            arith_req.b = AluW'(err_ff);
         end
         mcc_pkg::ST_MUL_P: begin
            arith_req.op = mcc_pkg::AR_MUL;
            arith_req.a  = AluW'(err_ff);
            arith_req.b  = AluW'(prop_gain_ff);
         end
         mcc_pkg::ST_MUL_I: begin
            arith_req.op = mcc_pkg::AR_MUL;
            arith_req.a  = AluW'(error_sum_ff);
            arith_req.b  = AluW'(integ_gain_ff);
         end
         mcc_pkg::ST_ADD: begin
            arith_req.a = acc_ff;
            arith_req.b = prod_ff;
         end
         mcc_pkg::ST_ABS: begin
            if (acc_ff[AluW-1]) begin
               arith_req.op = mcc_pkg::AR_SUB;
               arith_req.b  = acc_ff;
            end else begin
               arith_req.a = acc_ff;
            end
         end
         mcc_pkg::ST_CHK: begin
            arith_req.op = mcc_pkg::AR_SUB;
            arith_req.a  = acc_ff;
            arith_req.b  = AluW'(div_val) << 8;
         end
         mcc_pkg::ST_DIV: begin
            arith_req.op = mcc_pkg::AR_SUB;
            arith_req.a  = AluW'(rem_ff);
            arith_req.b  = AluW'(div_val) << step_ff;
         end
         default: begin
            arith_req.op = mcc_pkg::AR_ADD;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // sequencer and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         default_speed_ff  <= '0;
         prop_gain_ff      <= '0;
         integ_gain_ff     <= '0;
         tick_rate_ff      <= 10'd100;
         last_count_ff     <= '0;
         measured_speed_ff <= '0;
         error_sum_ff      <= '0;
         speed_target_ff   <= '0;
         target_pos_ff     <= '0;
         move_done_ff      <= 1'b1;
         drive_reverse_ff  <= 1'b0;
      end else begin
         // register writes, taken only while idle
         if (csr_write) begin
            case (csr_index)
               mcc_pkg::REG_DEFAULT_SPEED: begin
                  default_speed_ff <= $signed(csr_data);
                  speed_target_ff  <= 17'($signed(csr_data));
               end
               mcc_pkg::REG_PROP_GAIN:  prop_gain_ff  <= csr_data[7:0];
               mcc_pkg::REG_INTEG_GAIN: integ_gain_ff <= csr_data[7:0];
               mcc_pkg::REG_TICK_RATE:  tick_rate_ff  <= csr_data[9:0];
               default: begin
                  tick_rate_ff <= tick_rate_ff;
               end
            endcase
         end
         case (state_ff)
            // non-tick operations
            mcc_pkg::ST_EXEC: begin
               case (op_ff)
                  mcc_pkg::OP_START: begin
                     if (target_pos_ff[31]) begin
                        speed_target_ff <= arith_res[16:0];
                     end
                     move_done_ff <= 1'b0;
                  end
                  mcc_pkg::OP_ADD:  target_pos_ff <= mcc_pkg::sat32(arith_res);
                  mcc_pkg::OP_STOP: move_done_ff  <= 1'b1;
                  mcc_pkg::OP_CLEAR: begin
                     error_sum_ff      <= '0;
                     move_done_ff      <= 1'b1;
                     last_count_ff     <= '0;
                     speed_target_ff   <= 17'(default_speed_ff);
                     target_pos_ff     <= '0;
                     measured_speed_ff <= '0;
                  end
                  default: begin
                     move_done_ff <= move_done_ff;
                  end
               endcase
            end
            // velocity and new last count
            mcc_pkg::ST_VEL: begin
               measured_speed_ff <= mcc_pkg::sat32(arith_res);
               last_count_ff     <= mcc_pkg::sat32(AluW'(pos_ff));
            end
            // integral update, end of move when target reached
            mcc_pkg::ST_SUM: begin
               error_sum_ff <= mcc_pkg::sat32(arith_res);
               if (!in_range_ff) begin
                  move_done_ff <= 1'b1;
               end
            end
            // saturated drive
            mcc_pkg::ST_CHK: begin
               if (!res_neg) begin
                  drive_reverse_ff <= neg_ff;
               end
            end
            // last divider step
            mcc_pkg::ST_DIV: begin
               if (step_ff == 3'd0) begin
                  drive_reverse_ff <= neg_ff && (quo_next != 8'd0);
               end
            end
            default: begin
               drive_reverse_ff <= drive_reverse_ff;
            end
         endcase
      end
   end

   // working registers of the word in progress
   always_ff @(posedge clock) begin
      case (state_ff)
         mcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_ff    <= req_operation;
               count_ff <= req_encoder_count;
               dist_ff  <= req_distance;
               pwm_ff   <= '0;
               zero_ff  <= 1'b0;
            end
         end
         mcc_pkg::ST_EXEC: begin
            if (op_ff == mcc_pkg::OP_CLEAR) begin
               zero_ff <= 1'b1;
            end else if (op_ff == mcc_pkg::OP_START) begin
               zero_ff <= move_done_ff;
            end
         end
         mcc_pkg::ST_NEG: pos_ff <= arith_res[32:0];
         mcc_pkg::ST_CMP: begin
            in_range_ff <= (!target_pos_ff[31] && (|target_pos_ff) && res_pos) ||
                           (target_pos_ff[31] && res_neg);
         end
         mcc_pkg::ST_ERR:   err_ff  <= arith_res[32:0];
         mcc_pkg::ST_MUL_P: acc_ff  <= arith_res;
         mcc_pkg::ST_MUL_I: prod_ff <= arith_res;
         mcc_pkg::ST_ADD:   acc_ff  <= arith_res;
         mcc_pkg::ST_ABS: begin
            neg_ff <= acc_ff[AluW-1];
            acc_ff <= arith_res;
         end
         // magnitude of at least 256 quotients saturates, else start the divider
         mcc_pkg::ST_CHK: begin
            if (!res_neg) begin
               pwm_ff <= mcc_pkg::PwmMax;
            end else begin
               rem_ff  <= acc_ff[RemW-1:0];
               quo_ff  <= '0;
               step_ff <= 3'd7;
            end
         end
         // one restoring step per cycle
         mcc_pkg::ST_DIV: begin
            if (!res_neg) begin
               rem_ff <= arith_res[RemW-1:0];
            end
            quo_ff  <= quo_next;
            step_ff <= step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               pwm_ff <= quo_next;
            end
         end
         default: begin
            pwm_ff <= pwm_ff;
         end
      endcase
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pwm_ff     <= pwm_ff;
         rsp_reverse_ff <= drive_reverse_ff;
         rsp_done_ff    <= move_done_ff;
         rsp_speed_ff   <= measured_speed_ff;
         rsp_zero_ff    <= zero_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_duty     = rsp_pwm_ff;
   assign rsp_reverse      = rsp_reverse_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_speed        = rsp_speed_ff;
   assign rsp_zero_encoder = rsp_zero_ff;

   // an accepted word keeps the input side closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a word is in work");

   // a new result appears only out of the final sequencer step
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == mcc_pkg::ST_FINISH))
      else $error("result valid without a finished word");

   // an encoder zero request never comes with drive
   a_zero_no_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_encoder) |-> (rsp_pwm_duty == 8'd0))
      else $error("encoder zero request with nonzero drive");

endmodule
